FILE: hdl/multi_channel_pulse_period_meter_defines.svh
// Assertion macros for the file that checks itself.
// ASSERT_IMPLIES checks a consequent in the same cycle as its antecedent.
// ASSERT_NEXT checks a consequent starting in the cycle after its antecedent.
`ifndef MULTI_CHANNEL_PULSE_PERIOD_METER_DEFINES_SVH
`define MULTI_CHANNEL_PULSE_PERIOD_METER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/mcppm_pkg.sv
package mcppm_pkg;

   localparam int CHANNELS    = 3;
   localparam int PERIOD_BITS = 16;
   localparam int COUNT_BITS  = 16;
   localparam int PIN_COUNT   = 3;

   // Only channels that have a pin give a result.
   localparam int RESULTS  = (CHANNELS < PIN_COUNT) ? CHANNELS : PIN_COUNT;
   localparam int RES_BITS = $clog2(RESULTS + 1);

   localparam int FIELD_BITS   = 16;
   localparam int CHANNEL_BITS = 2;
   localparam int DIV_BITS     = 8;

   localparam logic [DIV_BITS-1:0]    TICK_DIVIDE_RESET = 8'd100;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX        = '1;
   localparam logic [31:0]            FIELD_MAX_WIDE    = 32'h0000_ffff;

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 72;
   localparam int RSP_USER_BITS = CHANNEL_BITS;

   // Input item layout, lowest bits last.
   typedef struct packed {
      logic [REQ_DATA_BITS-PIN_COUNT-3:0] pad;
      logic                               clear_sums;
      logic                               clear_counts;
      logic [PIN_COUNT-1:0]               level;
   } req_data_type;

   typedef struct packed {
      logic clear_counts;
      logic clear_sums;
   } tick_ctrl_type;

   typedef struct packed {
      logic                  edge_seen;
      logic [FIELD_BITS-1:0] pulses;
      logic [FIELD_BITS-1:0] pulse_total;
      logic [FIELD_BITS-1:0] period;
      logic [FIELD_BITS-1:0] min_period;
   } lane_result_type;

   // Result item layout, lowest bits last.
   typedef struct packed {
      logic [5:0]            pad;
      logic                  slow_flag;
      logic [FIELD_BITS-1:0] min_period;
      logic [FIELD_BITS-1:0] period;
      logic [FIELD_BITS-1:0] pulse_total;
      logic [FIELD_BITS-1:0] pulses;
      logic                  edge_seen;
   } rsp_data_type;

   function automatic logic [FIELD_BITS-1:0] sat_field(input logic [31:0] value);
      logic [FIELD_BITS-1:0] result;
      if (value > FIELD_MAX_WIDE) begin
         result = '1;
      end else begin
         result = value[FIELD_BITS-1:0];
      end
      return result;
   endfunction

endpackage

FILE: hdl/mcppm_lane.sv
// One channel: edge detection, period timer, counts and minimum period.
// The result shows the state as it stands after the current tick.
module mcppm_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tick,
   input  logic                      level,
   input  mcppm_pkg::tick_ctrl_type  ctrl,
   output mcppm_pkg::lane_result_type result
);

   logic                             prev_ff, prev_in;
   logic                             active_ff, active_in;
   logic [mcppm_pkg::PERIOD_BITS-1:0] timer_ff, timer_in;
   logic [mcppm_pkg::PERIOD_BITS-1:0] latched_ff, latched_in;
   logic [mcppm_pkg::PERIOD_BITS-1:0] smallest_ff, smallest_in;
   logic [mcppm_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [mcppm_pkg::COUNT_BITS-1:0]  total_ff, total_in;
   logic [mcppm_pkg::PERIOD_BITS-1:0] timer_run;
   logic                             edge_now;

   assign edge_now = prev_ff & ~level;

   always_comb begin
      if (active_ff && (timer_ff != mcppm_pkg::PERIOD_MAX)) begin
         timer_run = timer_ff + 1'b1;
      end else begin
         timer_run = timer_ff;
      end

      count_in    = ctrl.clear_counts ? '0 : count_ff;
      smallest_in = ctrl.clear_counts ? mcppm_pkg::PERIOD_MAX : smallest_ff;
      total_in    = ctrl.clear_sums ? '0 : total_ff;
      timer_in    = timer_run;
      latched_in  = latched_ff;
      active_in   = active_ff;
      prev_in     = level;

      if (edge_now) begin
         count_in  = count_in + 1'b1;
         total_in  = total_in + 1'b1;
         if (active_ff) begin
            latched_in = timer_run;
            if (timer_run < smallest_in) begin
               smallest_in = timer_run;
            end
         end
         timer_in  = '0;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= 1'b0;
         active_ff   <= 1'b0;
         timer_ff    <= '0;
         latched_ff  <= '0;
         smallest_ff <= mcppm_pkg::PERIOD_MAX;
         count_ff    <= '0;
         total_ff    <= '0;
      end else if (tick) begin
         prev_ff     <= prev_in;
         active_ff   <= active_in;
         timer_ff    <= timer_in;
         latched_ff  <= latched_in;
         smallest_ff <= smallest_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
      end
   end

   assign result.edge_seen   = edge_now;
   assign result.pulses      = mcppm_pkg::FIELD_BITS'(count_in);
   assign result.pulse_total = mcppm_pkg::FIELD_BITS'(total_in);
   assign result.period      = mcppm_pkg::sat_field(32'(latched_in));
   assign result.min_period  = mcppm_pkg::sat_field(32'(smallest_in));

endmodule

FILE: hdl/mcppm_merge.sv
// Takes a snapshot of all lane results for one tick and sends them out one
// per cycle while rsp_ready allows, through a registered output stage.
module mcppm_merge (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  mcppm_pkg::lane_result_type               lanes [mcppm_pkg::CHANNELS],
   input  logic                                     slow,
   output logic                                     ready,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [mcppm_pkg::RSP_DATA_BITS-1:0]      rsp_data,
   output logic [mcppm_pkg::RSP_USER_BITS-1:0]      rsp_user,
   output logic                                     rsp_last
);

   mcppm_pkg::lane_result_type           hold_ff [mcppm_pkg::RESULTS];
   mcppm_pkg::lane_result_type           hold_in [mcppm_pkg::RESULTS];
   logic                                 slow_ff;
   logic [mcppm_pkg::RES_BITS-1:0]       left_ff, left_in;
   logic                                 valid_ff, valid_in;
   mcppm_pkg::rsp_data_type              data_ff, data_in;
   logic [mcppm_pkg::RSP_USER_BITS-1:0]  user_ff, user_in;
   logic                                 last_ff, last_in;
   logic [mcppm_pkg::RES_BITS-1:0]       chan_idx;
   logic                                 out_free;
   logic                                 move;

   assign out_free = !valid_ff || rsp_ready;
   assign move     = (left_ff != '0) && out_free;
   assign ready    = (left_ff == '0) || ((left_ff == mcppm_pkg::RES_BITS'(1)) && move);
   assign chan_idx = mcppm_pkg::RES_BITS'(mcppm_pkg::RESULTS) - left_ff;

   always_comb begin
      for (int i = 0; i < mcppm_pkg::RESULTS; i++) begin
         if (load) begin
            hold_in[i] = lanes[i];
         end else if (move && (i < mcppm_pkg::RESULTS - 1)) begin
            hold_in[i] = hold_ff[(i + 1) % mcppm_pkg::RESULTS];
         end else begin
            hold_in[i] = hold_ff[i];
         end
      end

      if (load) begin
         left_in = mcppm_pkg::RES_BITS'(mcppm_pkg::RESULTS);
      end else if (move) begin
         left_in = left_ff - 1'b1;
      end else begin
         left_in = left_ff;
      end

      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (move) begin
         valid_in            = 1'b1;
         data_in.pad         = '0;
         data_in.slow_flag   = slow_ff;
         data_in.min_period  = hold_ff[0].min_period;
         data_in.period      = hold_ff[0].period;
         data_in.pulse_total = hold_ff[0].pulse_total;
         data_in.pulses      = hold_ff[0].pulses;
         data_in.edge_seen   = hold_ff[0].edge_seen;
         user_in             = mcppm_pkg::RSP_USER_BITS'(chan_idx);
         last_in             = (left_ff == mcppm_pkg::RES_BITS'(1));
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < mcppm_pkg::RESULTS; i++) begin
         hold_ff[i] <= hold_in[i];
      end
      if (load) begin
         slow_ff <= slow;
      end
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         left_ff  <= left_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   assign rsp_user  = user_ff;
   assign rsp_last  = last_ff;

endmodule

FILE: hdl/multi_channel_pulse_period_meter.sv
// Three-channel pulse period meter for anemometer style sensors.
// Each item on the req_ stream is one sample tick: the three pin levels and
// two clear requests. Every accepted item produces three items on the rsp_
// stream, one per channel in channel order, with tlast on the third. Each
// result carries the edge flag, pulse count, pulse total, latest period,
// minimum period and the shared slow-activity flag; tuser holds the channel.
// rsp_tvalid rises once the item has passed the snapshot buffer and then
// the output register; the rest follow one per cycle while rsp_tready is
// high. A new tick is taken as the final result of the previous one moves
// to the output register, which all three lane results share. When the
// receiver stalls, the output register holds its item, the snapshot buffer
// holds the rest, and req_tready drops until the last result of the
// buffered tick is on its way. The divider register tick_divide is written
// through csr_wr_en and csr_wr_data; the user must write it only while the
// block is idle, which the block itself does not enforce. Reset clears all
// channel state, sets the minimum periods to all ones and loads
// tick_divide with 100.
`include "multi_channel_pulse_period_meter_defines.svh"

module multi_channel_pulse_period_meter (
   input  logic                                  clock,
   input  logic                                  reset,
   // Sample tick input.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // level0, level1, level2, clear_counts, clear_sums, zero padding.
   input  logic [mcppm_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Channel results.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // edge_seen, pulses, pulse_total, period, min_period, slow_flag, padding.
   output logic [mcppm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // channel.
   output logic [mcppm_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   output logic                                  rsp_tlast,
   // Divider register write port.
   input  logic                                  csr_wr_en,
   input  logic [mcppm_pkg::DIV_BITS-1:0]        csr_wr_data
);

   mcppm_pkg::req_data_type               req_fields;
   mcppm_pkg::tick_ctrl_type              ctrl;
   mcppm_pkg::lane_result_type            lane_res [mcppm_pkg::CHANNELS];
   logic                                  req_accept;
   logic [mcppm_pkg::DIV_BITS-1:0]        tick_divide_ff;
   logic [mcppm_pkg::DIV_BITS-1:0]        divider_ff, divider_in;
   logic [mcppm_pkg::DIV_BITS-1:0]        divider_step;
   logic                                  slow_now;

   assign req_fields        = req_tdata;
   assign ctrl.clear_counts = req_fields.clear_counts;
   assign ctrl.clear_sums   = req_fields.clear_sums;
   assign req_accept        = req_tvalid && req_tready;

   // The configuration register changes only on reset or on a host write.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_divide_ff <= mcppm_pkg::TICK_DIVIDE_RESET;
      end else if (csr_wr_en) begin
         tick_divide_ff <= csr_wr_data;
      end
   end

   // The divider advances once per tick and wraps through zero; when it
   // lands on tick_divide the tick is flagged and the divider restarts.
   assign divider_step = divider_ff + 1'b1;
   assign slow_now     = (divider_step == tick_divide_ff);
   assign divider_in   = slow_now ? '0 : divider_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= '0;
      end else if (req_accept) begin
         divider_ff <= divider_in;
      end
   end

   // One lane per channel; channels past the pins see a steady low level.
   for (genvar c = 0; c < mcppm_pkg::CHANNELS; c++) begin : g_lane
      logic lane_level;
      if (c < mcppm_pkg::PIN_COUNT) begin : g_pin
         assign lane_level = req_fields.level[c];
      end else begin : g_nopin
         assign lane_level = 1'b0;
      end

      mcppm_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .tick   (req_accept),
         .level  (lane_level),
         .ctrl   (ctrl),
         .result (lane_res[c])
      );
   end

   mcppm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .lanes     (lane_res),
      .slow      (slow_now),
      .ready     (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata),
      .rsp_user  (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   // A flagged tick must restart the divider.
   `ASSERT_NEXT(a_divider_restart, clock, reset, req_accept && slow_now, divider_ff == '0)
   // The final result of a tick always belongs to the highest channel.
   `ASSERT_IMPLIES(a_last_channel, clock, reset, rsp_tvalid && rsp_tlast,
      rsp_tuser == mcppm_pkg::RSP_USER_BITS'(mcppm_pkg::RESULTS - 1))
   // A taken tick puts a result on the output once it has passed the snapshot buffer and the output register.
   `ASSERT_NEXT(a_result_follows, clock, reset, req_accept, ##1 rsp_tvalid)

endmodule
